// ===== rtl/core/hp_pkg.sv =====
// Types, constants and helpers shared by the request header parser.
package hp_pkg;

  localparam int MAX_REQUEST_BYTES = 2048;
  localparam int CNT_W = $clog2(MAX_REQUEST_BYTES + 1);

  typedef logic [CNT_W-1:0] cnt_t;
  localparam cnt_t MAX_CNT = cnt_t'(MAX_REQUEST_BYTES);

  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_SP  = 8'd32;
  localparam logic [7:0] CH_TAB = 8'd9;
  localparam logic [7:0] CH_SL  = 8'd47;

  typedef enum logic [3:0] {
    PH_METHOD    = 4'd0,
    PH_URL_START = 4'd1,
    PH_PREFIX    = 4'd2,
    PH_HOST      = 4'd3,
    PH_PATH      = 4'd4,
    PH_VERSION   = 4'd5,
    PH_HEADER    = 4'd6,
    PH_DRAIN     = 4'd7
  } phase_t;

  typedef enum logic [1:0] {
    HK_NAME   = 2'd0,
    HK_BLANK  = 2'd1,
    HK_VALUE  = 2'd2,
    HK_IGNORE = 2'd3
  } hk_t;

  typedef enum logic [1:0] {
    KIND_URL     = 2'd0,
    KIND_OK      = 2'd1,
    KIND_BAD     = 2'd2,
    KIND_TOOLONG = 2'd3
  } kind_t;

  typedef struct packed {
    phase_t     phase;
    logic [3:0] match_pos;
    logic       bad_seen;
    logic       alive_flag;
    logic       cr_pending;
    logic       line_is_empty;
    hk_t        header_kind;
    cnt_t       bytes_taken;
  } state_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] url_byte;
    logic       keep_alive;
  } result_t;

  function automatic state_t st_reset();
    state_t s;
    s.phase         = PH_METHOD;
    s.match_pos     = 4'd0;
    s.bad_seen      = 1'b0;
    s.alive_flag    = 1'b0;
    s.cr_pending    = 1'b0;
    s.line_is_empty = 1'b1;
    s.header_kind   = HK_NAME;
    s.bytes_taken   = '0;
    return s;
  endfunction

  // pattern characters, lower case
  function automatic logic [7:0] method_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "g";
      4'd1:    c = "e";
      4'd2:    c = "t";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] version_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "h";
      4'd1:    c = "t";
      4'd2:    c = "t";
      4'd3:    c = "p";
      4'd4:    c = "/";
      4'd5:    c = "1";
      4'd6:    c = ".";
      4'd7:    c = "1";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] prefix_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "h";
      4'd1:    c = "t";
      4'd2:    c = "t";
      4'd3:    c = "p";
      4'd4:    c = ":";
      4'd5:    c = "/";
      4'd6:    c = "/";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] conn_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "c";
      4'd1:    c = "o";
      4'd2:    c = "n";
      4'd3:    c = "n";
      4'd4:    c = "e";
      4'd5:    c = "c";
      4'd6:    c = "t";
      4'd7:    c = "i";
      4'd8:    c = "o";
      4'd9:    c = "n";
      4'd10:   c = ":";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] alive_ch(input logic [3:0] pos);
    logic [7:0] c;
    case (pos)
      4'd0:    c = "k";
      4'd1:    c = "e";
      4'd2:    c = "e";
      4'd3:    c = "p";
      4'd4:    c = "-";
      4'd5:    c = "a";
      4'd6:    c = "l";
      4'd7:    c = "i";
      4'd8:    c = "v";
      4'd9:    c = "e";
      default: c = 8'd0;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/http_request_header_parser.sv =====
// Top level of the HTTP/1.1 request header parser: parse state and result register.
//
//   channel | ports                                   | direction
//   --------+-----------------------------------------+----------
//   in      | in_valid, in_ready, in_byte_in[7:0]     | in
//   out     | out_valid, out_ready, out_kind[1:0],    | out
//           | out_url_byte[7:0], out_keep_alive       |
//
// One byte per cycle while in_ready is high: each accepted byte is parsed in the cycle it is taken
// and its result (if any) lands in the result register on the same edge.
// out_valid is registered and rises in the cycle after acceptance.
// in_ready is high while the result register is empty or being drained; while a
// result waits on a low out_ready, the next byte waits too, even one with no result.
// Synchronous active-low reset returns the parser to "expecting method".
module http_request_header_parser import hp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_url_byte,
  output logic       out_keep_alive
);

  state_t     st_r;
  state_t     st_nxt;
  result_t    res;
  logic       out_valid_r;
  kind_t      out_kind_r;
  logic [7:0] out_url_byte_r;
  logic       out_keep_alive_r;
  logic       in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  // per-byte parse step
  hp_step u_step (
    .cur     (st_r),
    .byte_in (in_byte_in),
    .nxt     (st_nxt),
    .res     (res)
  );

  // parser state advances only on an accepted byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= st_reset();
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= res.valid;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && res.valid) begin
      out_kind_r       <= res.kind;
      out_url_byte_r   <= res.url_byte;
      out_keep_alive_r <= res.keep_alive;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_url_byte   = out_url_byte_r;
  assign out_keep_alive = out_keep_alive_r;

  // url_byte is zero on every status item
  a_url_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_URL) |-> (out_url_byte_r == 8'd0))
    else $error("url_byte nonzero on status item");

  // keep-alive only travels with a good request
  a_alive_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_keep_alive_r) |-> (out_kind_r == KIND_OK))
    else $error("keep_alive set on non-ok item");

  // bytes discarded after an overlong request never produce an item
  a_drain_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && st_r.phase == PH_DRAIN) |=> !out_valid_r)
    else $error("item produced while draining");

  // the byte counter never reaches the limit between bytes
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.bytes_taken < MAX_CNT)
    else $error("byte counter out of range");

endmodule

// ===== rtl/core/hp_step.sv =====
// Next-state and result logic for one request byte.
module hp_step import hp_pkg::*; (
  input  state_t     cur,
  input  logic [7:0] byte_in,
  output state_t     nxt,
  output result_t    res
);

  always_comb begin
    state_t     s;
    logic [7:0] c;
    logic       draining;
    logic       line_end;
    logic       content;
    logic       url;
    logic       blank;
    logic       skip;
    logic       ok;

    s        = cur;
    c        = (byte_in >= "A" && byte_in <= "Z") ? byte_in + 8'd32 : byte_in;
    blank    = (byte_in == CH_SP) || (byte_in == CH_TAB);
    draining = (cur.phase == PH_DRAIN);
    line_end = 1'b0;
    content  = 1'b0;
    url      = 1'b0;
    skip     = 1'b0;
    ok       = 1'b0;
    res      = '0;

    // line framing: CR LF ends a line, a lone CR or LF marks the request bad unless draining
    if (s.cr_pending && byte_in == CH_LF) begin
      s.cr_pending = 1'b0;
      line_end     = 1'b1;
    end else begin
      if (s.cr_pending) begin
        s.cr_pending    = 1'b0;
        s.line_is_empty = 1'b0;
        if (!draining) s.bad_seen = 1'b1;
      end
      if (byte_in == CH_CR) begin
        s.cr_pending = 1'b1;
      end else if (byte_in == CH_LF) begin
        s.line_is_empty = 1'b0;
        if (!draining) s.bad_seen = 1'b1;
      end else begin
        s.line_is_empty = 1'b0;
        content         = 1'b1;
      end
    end

    if (draining) begin
      if (line_end) begin
        if (s.line_is_empty) s = st_reset();
        else s.line_is_empty = 1'b1;
      end
    end else begin
      s.bytes_taken = s.bytes_taken + cnt_t'(1);

      if (content && !s.bad_seen) begin
        unique case (s.phase)
          PH_METHOD: begin
            if (s.match_pos < 4'd3) begin
              if (c == method_ch(s.match_pos)) s.match_pos = s.match_pos + 4'd1;
              else s.bad_seen = 1'b1;
            end else if (blank) begin
              s.phase     = PH_URL_START;
              s.match_pos = 4'd0;
            end else begin
              s.bad_seen = 1'b1;
            end
          end
          PH_URL_START: begin
            if (byte_in == CH_SL) begin
              s.phase = PH_PATH;
              url     = 1'b1;
            end else if (c == "h") begin
              s.phase     = PH_PREFIX;
              s.match_pos = 4'd1;
            end else begin
              s.bad_seen = 1'b1;
            end
          end
          PH_PREFIX: begin
            if (s.match_pos < 4'd7 && c == prefix_ch(s.match_pos)) begin
              s.match_pos = s.match_pos + 4'd1;
              if (s.match_pos == 4'd7) s.phase = PH_HOST;
            end else begin
              s.bad_seen = 1'b1;
            end
          end
          PH_HOST: begin
            if (byte_in == CH_SL) begin
              s.phase = PH_PATH;
              url     = 1'b1;
            end else if (blank) begin
              s.bad_seen = 1'b1;
            end
          end
          PH_PATH: begin
            if (blank) begin
              s.phase     = PH_VERSION;
              s.match_pos = 4'd0;
            end else begin
              url = 1'b1;
            end
          end
          PH_VERSION: begin
            if (s.match_pos < 4'd8 && c == version_ch(s.match_pos))
              s.match_pos = s.match_pos + 4'd1;
            else
              s.bad_seen = 1'b1;
          end
          PH_HEADER: begin
            if (s.header_kind == HK_NAME) begin
              if (s.match_pos < 4'd11 && c == conn_ch(s.match_pos)) begin
                s.match_pos = s.match_pos + 4'd1;
                if (s.match_pos == 4'd11) s.header_kind = HK_BLANK;
              end else begin
                s.header_kind = HK_IGNORE;
              end
            end else begin
              if (s.header_kind == HK_BLANK) begin
                if (blank) begin
                  skip = 1'b1;
                end else begin
                  s.header_kind = HK_VALUE;
                  s.match_pos   = 4'd0;
                end
              end
              if (!skip && s.header_kind == HK_VALUE) begin
                if (s.match_pos < 4'd10 && c == alive_ch(s.match_pos))
                  s.match_pos = s.match_pos + 4'd1;
                else
                  s.header_kind = HK_IGNORE;
              end
            end
          end
          default: ;
        endcase
      end

      if (line_end && s.line_is_empty) begin
        // blank line closes the request
        ok             = !s.bad_seen && (s.phase == PH_HEADER);
        res.valid      = 1'b1;
        res.kind       = ok ? KIND_OK : KIND_BAD;
        res.keep_alive = ok && s.alive_flag;
        s              = st_reset();
      end else begin
        if (line_end) begin
          if (s.phase == PH_HEADER) begin
            if (s.header_kind == HK_VALUE && s.match_pos == 4'd10) s.alive_flag = 1'b1;
          end else if (!(s.phase == PH_VERSION && s.match_pos == 4'd8)) begin
            s.bad_seen = 1'b1;
          end
          s.phase         = PH_HEADER;
          s.header_kind   = HK_NAME;
          s.match_pos     = 4'd0;
          s.line_is_empty = 1'b1;
        end

        if (s.bytes_taken >= MAX_CNT) begin
          s.phase       = PH_DRAIN;
          s.bytes_taken = '0;
          res.valid     = 1'b1;
          res.kind      = KIND_TOOLONG;
        end else if (url && !s.bad_seen) begin
          res.valid    = 1'b1;
          res.kind     = KIND_URL;
          res.url_byte = byte_in;
        end
      end
    end

    nxt = s;
  end

endmodule
